@@ src/key_value_match_table_unit_macros.svh @@
// ============================================================================
// Key/value match table - assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off while in reset.
// ============================================================================
`ifndef KEY_VALUE_MATCH_TABLE_UNIT_MACROS_SVH
`define KEY_VALUE_MATCH_TABLE_UNIT_MACROS_SVH

// Same-cycle implication.
`define KVMT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kvmt assertion failed");

// Next-cycle implication.
`define KVMT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kvmt assertion failed");

`endif

@@ src/kvmt_pkg.sv @@
// ============================================================================
// Key/value match table - package
// Widths, command codes and the slot write bundle shared by all modules.
// ============================================================================
`default_nettype none

package kvmt_pkg;

    localparam int ENTRIES = 16;
    localparam int KEY_W   = 64;
    localparam int VAL_W   = 64;
    localparam int CMD_W   = 2;

    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET = 2'd0,
        CMD_GET = 2'd1,
        CMD_DEL = 2'd2,
        CMD_CLR = 2'd3
    } t_cmd;

    typedef logic [ENTRIES-1:0]            t_slot_vec;
    typedef logic [ENTRIES-1:0][KEY_W-1:0] t_key_arr;
    typedef logic [ENTRIES-1:0][VAL_W-1:0] t_val_arr;

    typedef struct packed {
        logic                    clr_all;
        t_slot_vec               ins_oh;
        t_slot_vec               val_oh;
        t_slot_vec               del_oh;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } t_slot_wr;

    typedef struct packed {
        logic                    found;
        logic signed [VAL_W-1:0] value;
        logic                    table_full;
    } t_result;

endpackage

`default_nettype wire

@@ src/kvmt_slot_store.sv @@
// ============================================================================
// Key/value match table - slot store
// Valid marks, keys and values of all slots; one write bundle per cycle.
// ============================================================================
`default_nettype none

module kvmt_slot_store (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_wr_en,
    input  wire kvmt_pkg::t_slot_wr   i_wr,
    output kvmt_pkg::t_slot_vec       o_valid,
    output kvmt_pkg::t_key_arr        o_key,
    output kvmt_pkg::t_val_arr        o_value
);
    import kvmt_pkg::*;

    t_slot_vec r_valid;
    t_key_arr  r_key;
    t_val_arr  r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            if (i_wr.clr_all) begin
                r_valid <= '0;
            end else begin
                r_valid <= (r_valid | i_wr.ins_oh) & ~i_wr.del_oh;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_wr_en && i_wr.ins_oh[i]) begin
                r_key[i] <= i_wr.key;
            end
            if (i_wr_en && i_wr.val_oh[i]) begin
                r_value[i] <= i_wr.value;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_value = r_value;

endmodule

`default_nettype wire

@@ src/kvmt_lookup.sv @@
// ============================================================================
// Key/value match table - lookup
// Parallel key compare, free slot pick, result and slot write decode.
// ============================================================================
`default_nettype none

module kvmt_lookup (
    input  wire kvmt_pkg::t_cmd              i_cmd,
    input  wire signed [kvmt_pkg::KEY_W-1:0] i_key,
    input  wire signed [kvmt_pkg::VAL_W-1:0] i_new_value,
    input  wire kvmt_pkg::t_slot_vec         i_valid,
    input  wire kvmt_pkg::t_key_arr          i_slot_key,
    input  wire kvmt_pkg::t_val_arr          i_slot_value,
    output kvmt_pkg::t_result                o_res,
    output kvmt_pkg::t_slot_wr               o_wr
);
    import kvmt_pkg::*;

    t_slot_vec         match;
    t_slot_vec         hit_oh;
    t_slot_vec         free;
    t_slot_vec         free_oh;
    logic              hit;
    logic              any_free;
    logic [VAL_W-1:0]  hit_value;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = i_valid[i] && (i_slot_key[i] == i_key);
        end
    end

    // lowest set bit isolation
    assign hit_oh   = match & (~match + t_slot_vec'(1));
    assign free     = ~i_valid;
    assign free_oh  = free & (~free + t_slot_vec'(1));
    assign hit      = |match;
    assign any_free = |free;

    always_comb begin
        hit_value = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_value = hit_value | (i_slot_value[i] & {VAL_W{hit_oh[i]}});
        end
    end

    always_comb begin
        o_res.found      = 1'b0;
        o_res.value      = MISS_VALUE;
        o_res.table_full = 1'b0;
        o_wr.clr_all     = 1'b0;
        o_wr.ins_oh      = '0;
        o_wr.val_oh      = '0;
        o_wr.del_oh      = '0;
        o_wr.key         = i_key;
        o_wr.value       = i_new_value;
        case (i_cmd)
            CMD_SET: begin
                if (hit) begin
                    o_res.found = 1'b1;
                    o_res.value = i_new_value;
                    o_wr.val_oh = hit_oh;
                end else if (any_free) begin
                    o_res.value = i_new_value;
                    o_wr.ins_oh = free_oh;
                    o_wr.val_oh = free_oh;
                end else begin
                    o_res.table_full = 1'b1;
                end
            end
            CMD_GET, CMD_DEL: begin
                if (hit) begin
                    o_res.found = 1'b1;
                    o_res.value = hit_value;
                    if (i_cmd == CMD_DEL) begin
                        o_wr.del_oh = hit_oh;
                    end
                end
            end
            CMD_CLR: begin
                o_wr.clr_all = 1'b1;
            end
            default: begin
                o_wr.clr_all = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/key_value_match_table_unit.sv @@
// An accepted item waits in the input register until its result is registered.
// Throughput: one item per cycle when the output is not stalled; each slot key
// is compared in the same cycle; the store is written as the result registers.
// Reset (i_rst_n low, synchronous): all slots marked empty, both stages empty.
// ============================================================================
// Key/value match table - top level
// Fully associative table of signed 64-bit keys and values with set, get,
// delete and clear commands; input register, lookup, result register.
// ============================================================================
`default_nettype none

`include "key_value_match_table_unit_macros.svh"

module key_value_match_table_unit (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [127:0] s_axis_tdata,   // key[63:0], new_value[127:64]
    input  wire  [1:0]   s_axis_tuser,   // command[1:0]
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [63:0]  m_axis_tdata,   // value[63:0]
    output logic [1:0]   m_axis_tuser    // found[0], table_full[1]
);
    import kvmt_pkg::*;

    logic                    r_in_valid;
    t_cmd                    r_in_cmd;
    logic signed [KEY_W-1:0] r_in_key;
    logic signed [VAL_W-1:0] r_in_val;
    logic                    r_out_valid;
    t_result                 r_out;

    logic      advance;
    logic      s_fire;
    t_slot_vec slot_valid;
    t_key_arr  slot_key;
    t_val_arr  slot_value;
    t_result   n_out;
    t_slot_wr  slot_wr;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_in_cmd <= t_cmd'(s_axis_tuser);
            r_in_key <= s_axis_tdata[KEY_W-1:0];
            r_in_val <= s_axis_tdata[KEY_W+VAL_W-1:KEY_W];
        end
    end

    kvmt_lookup u_lookup (
        .i_cmd        (r_in_cmd),
        .i_key        (r_in_key),
        .i_new_value  (r_in_val),
        .i_valid      (slot_valid),
        .i_slot_key   (slot_key),
        .i_slot_value (slot_value),
        .o_res        (n_out),
        .o_wr         (slot_wr)
    );

    kvmt_slot_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (advance),
        .i_wr    (slot_wr),
        .o_valid (slot_valid),
        .o_key   (slot_key),
        .o_value (slot_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.value;
    assign m_axis_tuser  = {r_out.table_full, r_out.found};

    `KVMT_ASSERT_IMP(a_full_is_miss,
        r_out_valid && r_out.table_full,
        !r_out.found && (r_out.value == MISS_VALUE))
    `KVMT_ASSERT_IMP(a_full_needs_all_valid, advance && n_out.table_full, &slot_valid)
    `KVMT_ASSERT_NXT(a_clear_empties, advance && (r_in_cmd == CMD_CLR), slot_valid == '0)
    `KVMT_ASSERT_NXT(a_insert_grows,
        advance && (r_in_cmd == CMD_SET) && !n_out.found && !n_out.table_full,
        $countones(slot_valid) == $countones($past(slot_valid)) + 1)

endmodule

`default_nettype wire
